### design/grid_cell_tangent_vertex_generator_defines.svh
// ----------------------------------------------------------------------------
// Grid cell tangent vertex generator assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef GRID_CELL_TANGENT_VERTEX_GENERATOR_DEFINES_SVH
`define GRID_CELL_TANGENT_VERTEX_GENERATOR_DEFINES_SVH

// same-cycle implication
`define GCTV_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GCTV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/gctv_pkg.sv
// ----------------------------------------------------------------------------
// Grid cell tangent vertex generator package
// Beat types, register indexes, divider widths and corner tables.
// ----------------------------------------------------------------------------
`default_nettype none

package gctv_pkg;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_GRID_PARTS  = 2'd0;
	localparam logic [1:0] REG_TEX_SCALE_U = 2'd1;
	localparam logic [1:0] REG_TEX_SCALE_V = 2'd2;

	// position divider: (idx*8192 + P) / (2P)
	localparam int POS_NW  = 22;
	localparam int POS_DW  = 10;
	// tangent divider: (8192*|dx| + |du|) / (2|du|)
	localparam int TAN_NW  = 30;
	localparam int TAN_DW  = 25;
	localparam int DIV_BPS = 2;
	localparam int POS_LAT = POS_NW / DIV_BPS;
	localparam int TAN_LAT = TAN_NW / DIV_BPS;

	localparam logic [2:0] CORNER_FIRST = 3'd0;
	localparam logic [2:0] CORNER_LAST  = 3'd5;

	typedef struct packed {
		logic [7:0] cell_col;
		logic [7:0] cell_row;
	} cell_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [23:0] tex_u;
		logic signed [23:0] tex_v;
		logic signed [23:0] tangent_x;
		logic signed [23:0] tangent_y;
		logic signed [23:0] tangent_z;
		logic signed [23:0] bitangent_x;
		logic signed [23:0] bitangent_y;
		logic signed [23:0] bitangent_z;
		logic [2:0]         corner;
		logic               last;
	} vert_t;

	// queue entry: classified cell ready for the back end
	typedef struct packed {
		logic [POS_NW-1:0]  num_x0;
		logic [POS_NW-1:0]  num_x1;
		logic [POS_NW-1:0]  num_y0;
		logic [POS_NW-1:0]  num_y1;
		logic [POS_DW-1:0]  den;
		logic signed [15:0] scale_u;
		logic signed [15:0] scale_v;
	} cell_item_t;

	// corner uses the far column (x1)
	function automatic logic corner_hi_x(input logic [2:0] c);
		logic r;
		case (c)
			3'd0: r = 1'b0;
			3'd1: r = 1'b1;
			3'd2: r = 1'b1;
			3'd3: r = 1'b1;
			3'd4: r = 1'b0;
			3'd5: r = 1'b0;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// corner uses the far row (y1)
	function automatic logic corner_hi_y(input logic [2:0] c);
		logic r;
		case (c)
			3'd0: r = 1'b0;
			3'd1: r = 1'b1;
			3'd2: r = 1'b0;
			3'd3: r = 1'b1;
			3'd4: r = 1'b0;
			3'd5: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### design/gctv_fifo.sv
// ----------------------------------------------------------------------------
// Cell queue
// Small register queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gctv_fifo #(
	parameter int DEPTH = 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire gctv_pkg::cell_item_t din,
	input  wire logic                 pop,
	output gctv_pkg::cell_item_t      dout,
	output logic                      not_empty,
	output logic                      full
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	gctv_pkg::cell_item_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CW'(DEPTH));
	assign dout      = mem_q[rd_ptr_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// write entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

### design/gctv_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accept cell beats, clamp the part count and form the divider operands.
// ----------------------------------------------------------------------------
`default_nettype none

module gctv_front #(
	parameter int MAX_PARTS = 256
) (
	input  wire logic                 cell_valid,
	output logic                      cell_stall,
	input  wire gctv_pkg::cell_t      cell_data,
	input  wire logic [8:0]           grid_parts,
	input  wire logic signed [15:0]   scale_u,
	input  wire logic signed [15:0]   scale_v,
	input  wire logic                 q_full,
	output logic                      push,
	output gctv_pkg::cell_item_t      item
);

	localparam int PCAP = (MAX_PARTS < 511) ? MAX_PARTS : 511;

	logic [8:0] p_eff;

	// offset numerator for index idx: idx*8192 + P
	function automatic logic [gctv_pkg::POS_NW-1:0] pos_num(input logic [8:0] idx,
			input logic [8:0] p);
		return {idx, 13'b0} + {13'b0, p};
	endfunction

	// clamp part count into 1..PCAP (MAX_PARTS, capped at 511)
	always_comb begin
		if (grid_parts == 9'd0) begin
			p_eff = 9'd1;
		end else if (grid_parts > 9'(PCAP)) begin
			p_eff = 9'(PCAP);
		end else begin
			p_eff = grid_parts;
		end
	end

	// build queue entry
	always_comb begin
		item.num_x0  = pos_num({1'b0, cell_data.cell_col}, p_eff);
		item.num_x1  = pos_num({1'b0, cell_data.cell_col} + 9'd1, p_eff);
		item.num_y0  = pos_num({1'b0, cell_data.cell_row}, p_eff);
		item.num_y1  = pos_num({1'b0, cell_data.cell_row} + 9'd1, p_eff);
		item.den     = {p_eff, 1'b0};
		item.scale_u = scale_u;
		item.scale_v = scale_v;
	end

	assign cell_stall = q_full;
	assign push       = cell_valid && !q_full;

endmodule

`default_nettype wire

### design/gctv_div.sv
// ----------------------------------------------------------------------------
// Pipelined divider
// Unsigned restoring division, DIV_BPS quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gctv_div #(
	parameter int NW  = 22,
	parameter int DW  = 10,
	parameter int BPS = 2
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic [NW-1:0]      quo
);

	localparam int STAGES = NW / BPS;

	logic [DW-1:0] rem_pipe_q [STAGES];
	logic [NW-1:0] nq_pipe_q  [STAGES];
	logic [DW-1:0] den_pipe_q [STAGES];

	for (genvar s = 0; s < STAGES; s++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [NW-1:0] nq_in;
		logic [DW-1:0] den_in;
		logic [DW-1:0] rem_out;
		logic [NW-1:0] nq_out;

		if (s == 0) begin : g_head
			assign rem_in = '0;
			assign nq_in  = num;
			assign den_in = den;
		end else begin : g_body
			assign rem_in = rem_pipe_q[s-1];
			assign nq_in  = nq_pipe_q[s-1];
			assign den_in = den_pipe_q[s-1];
		end

		// shift in numerator bits, subtract where the divisor fits
		always_comb begin
			logic [DW:0]   t;
			logic          ge;
			logic [DW-1:0] r;
			logic [NW-1:0] q;
			r = rem_in;
			q = nq_in;
			for (int b = 0; b < BPS; b++) begin
				t  = {r, q[NW-1]};
				ge = (t >= {1'b0, den_in});
				if (ge) begin
					t = t - {1'b0, den_in};
				end
				r = t[DW-1:0];
				q = {q[NW-2:0], ge};
			end
			rem_out = r;
			nq_out  = q;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_pipe_q[s] <= rem_out;
				nq_pipe_q[s]  <= nq_out;
				den_pipe_q[s] <= den_in;
			end
		end
	end

	assign quo = nq_pipe_q[STAGES-1];

endmodule

`default_nettype wire

### design/gctv_back.sv
// ----------------------------------------------------------------------------
// Back end
// Positions, texture coordinates, tangent frame and the six-beat emitter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_cell_tangent_vertex_generator_defines.svh"

module gctv_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	input  wire gctv_pkg::cell_item_t q_item,
	output logic                      pop,
	output logic                      vert_valid,
	input  wire logic                 vert_stall,
	output gctv_pkg::vert_t           vert
);

	localparam int PL = gctv_pkg::POS_LAT;
	localparam int TL = gctv_pkg::TAN_LAT;

	typedef struct packed {
		logic signed [15:0] px0;
		logic signed [15:0] px1;
		logic signed [15:0] py0;
		logic signed [15:0] py1;
		logic signed [23:0] tu0;
		logic signed [23:0] tu1;
		logic signed [23:0] tv0;
		logic signed [23:0] tv1;
		logic               zero;
		logic               neg_u;
		logic               neg_v;
	} tan_tag_t;

	// saturate offset minus one half to Q4.12
	function automatic logic signed [15:0] pos_sat(input logic [gctv_pkg::POS_NW-1:0] o);
		logic signed [22:0] d;
		d = $signed({1'b0, o}) - 23'sd2048;
		return (d > 23'sd32767) ? 16'sh7FFF : d[15:0];
	endfunction

	// divide by 256, round half away from zero, saturate to Q12.12
	function automatic logic signed [23:0] tex_sat(input logic signed [38:0] p);
		logic [38:0] m;
		logic [38:0] q;
		logic [38:0] nq;
		m  = p[38] ? 39'(-p) : 39'(p);
		q  = (m + 39'd128) >> 8;
		nq = -q;
		if (!p[38]) begin
			return (q > 39'd8388607) ? 24'sh7FFFFF : q[23:0];
		end
		return (q > 39'd8388608) ? 24'sh800000 : nq[23:0];
	endfunction

	// negate signed quotient and saturate
	function automatic logic signed [23:0] vec_sat(input logic [gctv_pkg::TAN_NW-1:0] q,
			input logic neg, input logic zero);
		logic [gctv_pkg::TAN_NW-1:0] nq;
		nq = -q;
		if (zero) begin
			return '0;
		end
		if (neg) begin
			return (q > 30'd8388607) ? 24'sh7FFFFF : q[23:0];
		end
		return (q > 30'd8388608) ? 24'sh800000 : nq[23:0];
	endfunction

	logic adv;
	logic load;
	logic take;

	// position section
	logic [PL-1:0]          pv_q;
	logic signed [15:0]     psu_q [PL];
	logic signed [15:0]     psv_q [PL];
	logic [gctv_pkg::POS_NW-1:0] ox0, ox1, oy0, oy1;

	// stage 1: positions and scale products
	logic                   v_s1;
	logic signed [15:0]     px0_s1, px1_s1, py0_s1, py1_s1;
	logic signed [38:0]     pu0_s1, pu1_s1, pv0_s1, pv1_s1;

	// stage 2: texture coordinates
	logic                   v_s2;
	logic signed [15:0]     px0_s2, px1_s2, py0_s2, py1_s2;
	logic signed [23:0]     tu0_s2, tu1_s2, tv0_s2, tv1_s2;

	// tangent section
	logic signed [24:0]     du, dv;
	logic [23:0]            mag_u, mag_v;
	logic [15:0]            dx, dy;
	logic [gctv_pkg::TAN_NW-1:0] tnum_x, tnum_y, tq_x, tq_y;
	tan_tag_t               tag_in;
	logic [TL-1:0]          tv_q;
	tan_tag_t               ttag_q [TL];

	// emitter
	logic                   hold_v_q;
	logic [2:0]             cnt_q;
	tan_tag_t               hold_tag_q;
	logic signed [23:0]     hold_tx_q;
	logic signed [23:0]     hold_by_q;
	logic                   hx, hy;

	assign load = adv && tv_q[TL-1];
	assign take = hold_v_q && !vert_stall;
	assign adv  = !tv_q[TL-1] || !hold_v_q || (!vert_stall && cnt_q == gctv_pkg::CORNER_LAST);
	assign pop  = adv && q_valid;

	// position dividers
	gctv_div #(.NW(gctv_pkg::POS_NW), .DW(gctv_pkg::POS_DW), .BPS(gctv_pkg::DIV_BPS))
		u_div_x0 (.clk(clk), .en(adv), .num(q_item.num_x0), .den(q_item.den), .quo(ox0));
	gctv_div #(.NW(gctv_pkg::POS_NW), .DW(gctv_pkg::POS_DW), .BPS(gctv_pkg::DIV_BPS))
		u_div_x1 (.clk(clk), .en(adv), .num(q_item.num_x1), .den(q_item.den), .quo(ox1));
	gctv_div #(.NW(gctv_pkg::POS_NW), .DW(gctv_pkg::POS_DW), .BPS(gctv_pkg::DIV_BPS))
		u_div_y0 (.clk(clk), .en(adv), .num(q_item.num_y0), .den(q_item.den), .quo(oy0));
	gctv_div #(.NW(gctv_pkg::POS_NW), .DW(gctv_pkg::POS_DW), .BPS(gctv_pkg::DIV_BPS))
		u_div_y1 (.clk(clk), .en(adv), .num(q_item.num_y1), .den(q_item.den), .quo(oy1));

	// carry scales alongside the position dividers
	always_ff @(posedge clk) begin
		if (adv) begin
			psu_q[0] <= q_item.scale_u;
			psv_q[0] <= q_item.scale_v;
			for (int i = 1; i < PL; i++) begin
				psu_q[i] <= psu_q[i-1];
				psv_q[i] <= psv_q[i-1];
			end
		end
	end

	// stage 1 and 2 datapath
	always_ff @(posedge clk) begin
		if (adv) begin
			px0_s1 <= pos_sat(ox0);
			px1_s1 <= pos_sat(ox1);
			py0_s1 <= pos_sat(oy0);
			py1_s1 <= pos_sat(oy1);
			pu0_s1 <= psu_q[PL-1] * $signed({1'b0, ox0});
			pu1_s1 <= psu_q[PL-1] * $signed({1'b0, ox1});
			pv0_s1 <= psv_q[PL-1] * $signed({1'b0, oy0});
			pv1_s1 <= psv_q[PL-1] * $signed({1'b0, oy1});
			px0_s2 <= px0_s1;
			px1_s2 <= px1_s1;
			py0_s2 <= py0_s1;
			py1_s2 <= py1_s1;
			tu0_s2 <= tex_sat(pu0_s1);
			tu1_s2 <= tex_sat(pu1_s1);
			tv0_s2 <= tex_sat(pv0_s1);
			tv1_s2 <= tex_sat(pv1_s1);
		end
	end

	// edge and UV deltas; both triangles share the same frame
	always_comb begin
		du     = {tu1_s2[23], tu1_s2} - {tu0_s2[23], tu0_s2};
		dv     = {tv1_s2[23], tv1_s2} - {tv0_s2[23], tv0_s2};
		mag_u  = du[24] ? 24'(-du) : du[23:0];
		mag_v  = dv[24] ? 24'(-dv) : dv[23:0];
		dx     = px1_s2 - px0_s2;
		dy     = py1_s2 - py0_s2;
		tnum_x = {1'b0, dx, 13'b0} + {6'b0, mag_u};
		tnum_y = {1'b0, dy, 13'b0} + {6'b0, mag_v};
		tag_in.px0   = px0_s2;
		tag_in.px1   = px1_s2;
		tag_in.py0   = py0_s2;
		tag_in.py1   = py1_s2;
		tag_in.tu0   = tu0_s2;
		tag_in.tu1   = tu1_s2;
		tag_in.tv0   = tv0_s2;
		tag_in.tv1   = tv1_s2;
		tag_in.zero  = (du == '0) || (dv == '0);
		tag_in.neg_u = du[24];
		tag_in.neg_v = dv[24];
	end

	// tangent dividers
	gctv_div #(.NW(gctv_pkg::TAN_NW), .DW(gctv_pkg::TAN_DW), .BPS(gctv_pkg::DIV_BPS))
		u_div_tx (.clk(clk), .en(adv), .num(tnum_x), .den({mag_u, 1'b0}), .quo(tq_x));
	gctv_div #(.NW(gctv_pkg::TAN_NW), .DW(gctv_pkg::TAN_DW), .BPS(gctv_pkg::DIV_BPS))
		u_div_by (.clk(clk), .en(adv), .num(tnum_y), .den({mag_v, 1'b0}), .quo(tq_y));

	// carry vertex data alongside the tangent dividers
	always_ff @(posedge clk) begin
		if (adv) begin
			ttag_q[0] <= tag_in;
			for (int i = 1; i < TL; i++) begin
				ttag_q[i] <= ttag_q[i-1];
			end
		end
	end

	// advance valid bits through every section
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			tv_q <= '0;
		end else if (adv) begin
			pv_q <= {pv_q[PL-2:0], q_valid};
			v_s1 <= pv_q[PL-1];
			v_s2 <= v_s1;
			tv_q <= {tv_q[TL-2:0], v_s2};
		end
	end

	// emitter control: six beats per cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			cnt_q    <= gctv_pkg::CORNER_FIRST;
		end else begin
			if (take) begin
				if (cnt_q == gctv_pkg::CORNER_LAST) begin
					hold_v_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
			if (load) begin
				hold_v_q <= 1'b1;
				cnt_q    <= gctv_pkg::CORNER_FIRST;
			end
		end
	end

	// capture finished cell
	always_ff @(posedge clk) begin
		if (load) begin
			hold_tag_q <= ttag_q[TL-1];
			hold_tx_q  <= vec_sat(tq_x, ttag_q[TL-1].neg_u, ttag_q[TL-1].zero);
			hold_by_q  <= vec_sat(tq_y, ttag_q[TL-1].neg_v, ttag_q[TL-1].zero);
		end
	end

	// select corner fields
	assign hx = gctv_pkg::corner_hi_x(cnt_q);
	assign hy = gctv_pkg::corner_hi_y(cnt_q);

	always_comb begin
		vert.pos_x       = hx ? hold_tag_q.px1 : hold_tag_q.px0;
		vert.pos_y       = hy ? hold_tag_q.py1 : hold_tag_q.py0;
		vert.tex_u       = hx ? hold_tag_q.tu1 : hold_tag_q.tu0;
		vert.tex_v       = hy ? hold_tag_q.tv1 : hold_tag_q.tv0;
		vert.tangent_x   = hold_tx_q;
		vert.tangent_y   = '0;
		vert.tangent_z   = '0;
		vert.bitangent_x = '0;
		vert.bitangent_y = hold_by_q;
		vert.bitangent_z = '0;
		vert.corner      = cnt_q;
		vert.last        = (cnt_q == gctv_pkg::CORNER_LAST);
	end

	assign vert_valid = hold_v_q;

	`GCTV_ASSERT_NEXT(a_hold_on_stall, hold_v_q && vert_stall, hold_v_q && $stable(cnt_q), "emitter moved while stalled")
	`GCTV_ASSERT_NEXT(a_corner_step, take && !load && (cnt_q != gctv_pkg::CORNER_LAST), hold_v_q && (cnt_q == $past(cnt_q) + 3'd1), "corner did not step")
	`GCTV_ASSERT_IMPL(a_no_drop, tv_q[TL-1] && !adv, hold_v_q, "finished cell blocked with emitter idle")

endmodule

`default_nettype wire

### design/grid_cell_tangent_vertex_generator.sv
// ----------------------------------------------------------------------------
// Grid cell tangent vertex generator
// One cell in, its six triangle vertices out with position, texture and frame.
// ----------------------------------------------------------------------------
// Each accepted cell yields six vertex beats, one per cycle when the output is
// not stalled, so the steady cell rate is set by the one-vertex-per-cycle
// output emitter. Cells are queued behind a two-entry queue and pass through a
// pipelined position divider (11 stages), two texture stages and a pipelined
// tangent divider (15 stages) on the way to the emitter. Registers sit at byte
// addresses 0 (grid_parts), 4 (tex_scale_u) and 8 (tex_scale_v); write them
// only while no cell is in flight.
`default_nettype none

module grid_cell_tangent_vertex_generator #(
	parameter int MAX_PARTS   = 256,
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cell_valid,
	output logic                 cell_stall,
	input  wire gctv_pkg::cell_t cell_data,
	output logic                 vert_valid,
	input  wire logic            vert_stall,
	output gctv_pkg::vert_t      vert,
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [3:0]      paddr,
	input  wire logic [31:0]     pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	logic [8:0]           grid_parts_q;
	logic signed [15:0]   scale_u_q;
	logic signed [15:0]   scale_v_q;
	logic                 wr_en;
	logic                 q_full;
	logic                 q_valid;
	logic                 push;
	logic                 pop;
	gctv_pkg::cell_item_t f_item;
	gctv_pkg::cell_item_t q_item;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_parts_q <= 9'd1;
			scale_u_q    <= 16'sd256;
			scale_v_q    <= 16'sd256;
		end else if (wr_en) begin
			case (paddr[3:2])
				gctv_pkg::REG_GRID_PARTS:  grid_parts_q <= pwdata[8:0];
				gctv_pkg::REG_TEX_SCALE_U: scale_u_q    <= pwdata[15:0];
				gctv_pkg::REG_TEX_SCALE_V: scale_v_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (paddr[3:2])
			gctv_pkg::REG_GRID_PARTS:  prdata = {23'b0, grid_parts_q};
			gctv_pkg::REG_TEX_SCALE_U: prdata = {16'b0, scale_u_q};
			gctv_pkg::REG_TEX_SCALE_V: prdata = {16'b0, scale_v_q};
			default:                   prdata = '0;
		endcase
	end

	gctv_front #(.MAX_PARTS(MAX_PARTS)) u_front (
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.cell_data  (cell_data),
		.grid_parts (grid_parts_q),
		.scale_u    (scale_u_q),
		.scale_v    (scale_v_q),
		.q_full     (q_full),
		.push       (push),
		.item       (f_item)
	);

	gctv_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (f_item),
		.pop       (pop),
		.dout      (q_item),
		.not_empty (q_valid),
		.full      (q_full)
	);

	gctv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.pop        (pop),
		.vert_valid (vert_valid),
		.vert_stall (vert_stall),
		.vert       (vert)
	);

endmodule

`default_nettype wire

### tb/sv/gctv_checker.sv
// ----------------------------------------------------------------------------
// Grid cell tangent vertex checker
// Tracks register writes and accepted cells on the input port, computes the
// six vertices of each cell, and compares every vertex beat with the oldest
// vertex still outstanding.
// ----------------------------------------------------------------------------
`default_nettype none

module gctv_checker (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cell_valid,
	input  wire logic            cell_stall,
	input  wire gctv_pkg::cell_t cell_data,
	input  wire logic            vert_valid,
	input  wire logic            vert_stall,
	input  wire gctv_pkg::vert_t vert,
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [3:0]      paddr,
	input  wire logic [31:0]     pwdata,
	output int                   errors,
	output int                   pending,
	output int                   cells_seen,
	output int                   verts_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  PARTS_LIMIT = 256;
	localparam longint SAT24_HI = 64'sd8388607;
	localparam longint SAT24_LO = -64'sd8388608;

	// shadow copy of the registers
	logic [8:0]  grid_parts;
	logic [15:0] scale_u;
	logic [15:0] scale_v;

	gctv_pkg::vert_t vert_q[$];

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// divide rounding to nearest, ties away from zero
	function automatic longint div_nearest(longint n, longint d);
		longint un;
		longint ud;
		longint q;
		un = n < 0 ? -n : n;
		ud = d < 0 ? -d : d;
		q = (un * 2 + ud) / (ud * 2);
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	// build the six vertices of one cell and queue them
	task automatic queue_cell_vertices(input gctv_pkg::cell_t c);
		int     hx[6];
		int     hy[6];
		longint p;
		longint su;
		longint sv;
		longint px[2];
		longint py[2];
		longint tu[2];
		longint tv[2];
		longint tx[2];
		longint ty[2];
		longint bx[2];
		longint by[2];
		longint ox;
		longint oy;
		longint e1x, e1y, e2x, e2y, du1, dv1, du2, dv2, det;
		int     a, b, m;
		gctv_pkg::vert_t v;
		hx = '{0, 1, 1, 1, 0, 0};
		hy = '{0, 1, 0, 1, 0, 1};
		p = grid_parts;
		if (p < 1) p = 1;
		if (p > PARTS_LIMIT) p = PARTS_LIMIT;
		su = longint'($signed(scale_u));
		sv = longint'($signed(scale_v));
		for (int k = 0; k < 2; k++) begin
			ox = ((longint'(c.cell_col) + k) * 8192 + p) / (2 * p);
			oy = ((longint'(c.cell_row) + k) * 8192 + p) / (2 * p);
			px[k] = clamp(ox - 2048, -32768, 32767);
			py[k] = clamp(oy - 2048, -32768, 32767);
			tu[k] = clamp(div_nearest(su * ox, 256), SAT24_LO, SAT24_HI);
			tv[k] = clamp(div_nearest(sv * oy, 256), SAT24_LO, SAT24_HI);
		end
		for (int t = 0; t < 2; t++) begin
			a = 3 * t;
			b = a + 1;
			m = a + 2;
			e1x = px[hx[b]] - px[hx[a]];
			e1y = py[hy[b]] - py[hy[a]];
			e2x = px[hx[m]] - px[hx[a]];
			e2y = py[hy[m]] - py[hy[a]];
			du1 = tu[hx[b]] - tu[hx[a]];
			dv1 = tv[hy[b]] - tv[hy[a]];
			du2 = tu[hx[m]] - tu[hx[a]];
			dv2 = tv[hy[m]] - tv[hy[a]];
			det = du1 * dv2 - du2 * dv1;
			if (det == 0) begin
				tx[t] = 0; ty[t] = 0; bx[t] = 0; by[t] = 0;
			end else begin
				tx[t] = clamp(-div_nearest((dv2 * e1x - dv1 * e2x) * 4096, det),
					SAT24_LO, SAT24_HI);
				ty[t] = clamp(-div_nearest((dv2 * e1y - dv1 * e2y) * 4096, det),
					SAT24_LO, SAT24_HI);
				bx[t] = clamp(-div_nearest((du1 * e2x - du2 * e1x) * 4096, det),
					SAT24_LO, SAT24_HI);
				by[t] = clamp(-div_nearest((du1 * e2y - du2 * e1y) * 4096, det),
					SAT24_LO, SAT24_HI);
			end
		end
		for (int k = 0; k < 6; k++) begin
			v.pos_x       = px[hx[k]][15:0];
			v.pos_y       = py[hy[k]][15:0];
			v.tex_u       = tu[hx[k]][23:0];
			v.tex_v       = tv[hy[k]][23:0];
			v.tangent_x   = tx[k / 3][23:0];
			v.tangent_y   = ty[k / 3][23:0];
			v.tangent_z   = '0;
			v.bitangent_x = bx[k / 3][23:0];
			v.bitangent_y = by[k / 3][23:0];
			v.bitangent_z = '0;
			v.corner      = 3'(k);
			v.last        = (3'(k) == gctv_pkg::CORNER_LAST);
			vert_q = {vert_q, v};
		end
	endtask

	task automatic field_check(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// compare one vertex beat with the oldest outstanding vertex
	task automatic check_vertex(input gctv_pkg::vert_t got);
		gctv_pkg::vert_t want;
		if (vert_q.size() == 0) begin
			$error("vertex beat with nothing outstanding (corner %0d)", got.corner);
			errors++;
			return;
		end
		want = vert_q.pop_front();
		field_check("pos_x", want.pos_x, got.pos_x);
		field_check("pos_y", want.pos_y, got.pos_y);
		field_check("tex_u", want.tex_u, got.tex_u);
		field_check("tex_v", want.tex_v, got.tex_v);
		field_check("tangent_x", want.tangent_x, got.tangent_x);
		field_check("tangent_y", want.tangent_y, got.tangent_y);
		field_check("tangent_z", want.tangent_z, got.tangent_z);
		field_check("bitangent_x", want.bitangent_x, got.bitangent_x);
		field_check("bitangent_y", want.bitangent_y, got.bitangent_y);
		field_check("bitangent_z", want.bitangent_z, got.bitangent_z);
		field_check("corner", want.corner, got.corner);
		field_check("last", want.last, got.last);
	endtask

	initial begin
		errors = 0;
		cells_seen = 0;
		verts_seen = 0;
	end

	assign pending = vert_q.size();

	// follow register writes, cell beats and vertex beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_parts <= 9'd1;
			scale_u    <= 16'd256;
			scale_v    <= 16'd256;
		end else begin
			if (psel && penable && pwrite) begin
				case (paddr[3:2])
					gctv_pkg::REG_GRID_PARTS:  grid_parts <= pwdata[8:0];
					gctv_pkg::REG_TEX_SCALE_U: scale_u    <= pwdata[15:0];
					gctv_pkg::REG_TEX_SCALE_V: scale_v    <= pwdata[15:0];
					default: ;
				endcase
			end
			if (cell_valid && !cell_stall) begin
				queue_cell_vertices(cell_data);
				cells_seen++;
			end
			if (vert_valid && !vert_stall) begin
				check_vertex(vert);
				verts_seen++;
			end
		end
	end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Grid cell tangent vertex generator testbench
// Writes register settings between phases, feeds directed and random cells in
// bursts with a stalling vertex sink, and leaves the vertex checking to the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 60;
	localparam int IDLE_LIMIT   = 5000;
	localparam int LONG_HOLD    = 300;

	logic            clk;
	logic            arst_n;
	logic            cell_valid;
	logic            cell_stall;
	gctv_pkg::cell_t cell_data;
	logic            vert_valid;
	logic            vert_stall;
	gctv_pkg::vert_t vert;
	logic            psel;
	logic            penable;
	logic            pwrite;
	logic [3:0]      paddr;
	logic [31:0]     pwdata;
	logic [31:0]     prdata;
	logic            pready;

	int errors;
	int pending;
	int cells_seen;
	int verts_seen;
	int stall_mode;
	bit hold_req;
	bit steady;
	int burst_left;
	int idle_cycles;
	int parts_now;

	grid_cell_tangent_vertex_generator i_dut (
		.clk(clk), .arst_n(arst_n),
		.cell_valid(cell_valid), .cell_stall(cell_stall), .cell_data(cell_data),
		.vert_valid(vert_valid), .vert_stall(vert_stall), .vert(vert),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	gctv_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.cell_valid(cell_valid), .cell_stall(cell_stall), .cell_data(cell_data),
		.vert_valid(vert_valid), .vert_stall(vert_stall), .vert(vert),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .errors(errors), .pending(pending),
		.cells_seen(cells_seen), .verts_seen(verts_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// vertex sink: stall pattern, plus a long hold-off on request
	initial begin
		vert_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				vert_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
				vert_stall <= 1'b0;
			end else begin
				case (stall_mode)
					0: vert_stall <= 1'b0;
					1: vert_stall <= ($urandom_range(0, 3) == 0);
					default: vert_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// watchdog: end the run when nothing moves for too long
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((cell_valid && !cell_stall) || (vert_valid && !vert_stall) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[grid_cell_tangent_vertex_generator] ERROR");
				$finish;
			end
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// wait for every outstanding vertex, then let the pipeline settle
	task automatic drain;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input int parts, input int su, input int sv);
		drain();
		reg_write(gctv_pkg::REG_GRID_PARTS, 32'(parts));
		reg_write(gctv_pkg::REG_TEX_SCALE_U, 32'(su));
		reg_write(gctv_pkg::REG_TEX_SCALE_V, 32'(sv));
		parts_now = parts;
	endtask

	// offer one cell beat; idle between bursts unless streaming steadily
	task automatic send_cell(input logic [7:0] col, input logic [7:0] row);
		cell_valid <= 1'b1;
		cell_data  <= '{cell_col: col, cell_row: row};
		do @(posedge clk); while (cell_stall);
		if (burst_left > 0) begin
			burst_left--;
		end else if (!steady) begin
			burst_left = $urandom_range(0, 8);
			if ($urandom_range(0, 2) == 0) begin
				cell_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	task automatic send_random_cell;
		int lim;
		lim = parts_now < 1 ? 1 : (parts_now > 256 ? 256 : parts_now);
		if ($urandom_range(0, 7) == 0)
			send_cell(8'($urandom), 8'($urandom));
		else
			send_cell(8'($urandom_range(0, lim - 1)), 8'($urandom_range(0, lim - 1)));
	endtask

	task automatic end_beats;
		cell_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		arst_n     = 1'b0;
		cell_valid = 1'b0;
		cell_data  = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		stall_mode = 0;
		hold_req   = 1'b0;
		steady     = 1'b0;
		burst_left = 0;
		parts_now  = 1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, in-range and out-of-range cells
		send_cell(8'd0, 8'd0);
		send_cell(8'd1, 8'd1);
		send_cell(8'd255, 8'd255);
		end_beats();

		// zero part count acts as one; unmapped register ignored
		set_config(0, 16'h7FFF, 16'h8000);
		reg_write(2'd3, 32'hFFFF_FFFF);
		send_cell(8'd0, 8'd0);
		send_cell(8'd255, 8'd0);
		end_beats();

		// full part count with extreme scales
		set_config(256, 16'h8000, 16'h7FFF);
		send_cell(8'd0, 8'd0);
		send_cell(8'd255, 8'd255);
		send_cell(8'd128, 8'd37);
		send_cell(8'h55, 8'hAA);
		end_beats();

		// part count above the maximum; zero scales give zero determinant
		set_config(511, 0, 0);
		send_cell(8'd0, 8'd255);
		send_cell(8'd17, 8'd200);
		end_beats();
		set_config(7, 0, 16'h0180);
		send_cell(8'd6, 8'd6);
		send_cell(8'd3, 8'd0);
		end_beats();
		set_config(2, 16'hFF00, 16'h0001);
		send_cell(8'd0, 8'd1);
		send_cell(8'd1, 8'd0);
		end_beats();

		// random phases with random settings and sink behavior
		for (int ph = 0; ph < 7; ph++) begin
			case ($urandom_range(0, 3))
				0: set_config(256, 16'($urandom), 16'($urandom));
				1: set_config($urandom_range(0, 511), 16'($urandom), 16'($urandom));
				default: set_config($urandom_range(1, 16),
					$urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024);
			endcase
			stall_mode = ph % 3;
			// fill the block against a held sink with a gapless stream
			if (ph == 2) begin
				hold_req = 1'b1;
				steady   = 1'b1;
				for (int n = 0; n < 40; n++) send_random_cell();
				steady   = 1'b0;
			end else begin
				for (int n = 0; n < 19; n++) send_random_cell();
			end
			end_beats();
			// pause until every vertex is back
			if (ph == 4) begin
				while (pending != 0) @(posedge clk);
				for (int n = 0; n < 4; n++) send_random_cell();
				end_beats();
			end
		end

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d cells and %0d vertex beats over several register settings,",
			cells_seen, verts_seen);
		$display("including extreme scales and part counts, with bursts and sink stalls.");
		if (errors == 0 && pending == 0)
			$display("[grid_cell_tangent_vertex_generator] OK");
		else
			$display("[grid_cell_tangent_vertex_generator] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
